// ===== rtl/core/unicycle_point_stabilizer_assert.svh =====
// ----------------------------------------------------------------------------
// unicycle point stabilizer assertion macros
// clocked, reset-qualified implication checks used by the top level
// ----------------------------------------------------------------------------
`ifndef UNICYCLE_POINT_STABILIZER_ASSERT_SVH
`define UNICYCLE_POINT_STABILIZER_ASSERT_SVH

// same-cycle implication
`define USP_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define USP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/usp_pkg.sv =====
// ----------------------------------------------------------------------------
// usp_pkg
// shared types, constants and tables of the unicycle point stabilizer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package usp_pkg;

    localparam int FRAC_BITS_DEF    = 16;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam int CNT_W     = 5;
    localparam int MUL_STEPS = 28;
    localparam int DIV_STEPS = 25;

    localparam logic signed [32:0] CORDIC_GAIN_Q30 = 33'sd652032874;
    localparam logic signed [15:0] PI_Q13          = 16'sd25736;
    localparam logic signed [15:0] HALF_PI_Q13     = 16'sd12868;

    // configuration register indexes
    localparam logic [2:0] REG_TARGET_X     = 3'd0;
    localparam logic [2:0] REG_TARGET_Y     = 3'd1;
    localparam logic [2:0] REG_GAIN_LINEAR  = 3'd2;
    localparam logic [2:0] REG_GAIN_ANGULAR = 3'd3;
    localparam logic [2:0] REG_SOFTENING    = 3'd4;
    localparam logic [2:0] REG_OFFSET       = 3'd5;

    // operand pairs of the serial multiplier
    typedef enum logic [2:0] {
        MS_CEX,
        MS_SEY,
        MS_CEY,
        MS_SEX_NEG,
        MS_GAIN
    } t_mul_sel;

    typedef struct packed {
        logic             load;
        logic             cord_init;
        logic             cord_step;
        logic             trig_fin;
        logic             mul_init;
        logic             mul_clr;
        t_mul_sel         mul_sel;
        logic             mul_step;
        logic             cap_x;
        logic             cap_y;
        logic             div_init;
        logic             div_step;
        logic             res_store;
        logic             comp;
        logic [CNT_W-1:0] idx;
        logic             out_load;
    } t_dp_cmd;

    // floored atan(2^-i) in Q30
    function automatic logic signed [32:0] atan_q30(input logic [CNT_W-1:0] i);
        logic signed [32:0] v;
        case (i)
            5'd0:    v = 33'sd843314856;
            5'd1:    v = 33'sd497837829;
            5'd2:    v = 33'sd263043836;
            5'd3:    v = 33'sd133525158;
            5'd4:    v = 33'sd67021686;
            5'd5:    v = 33'sd33543515;
            5'd6:    v = 33'sd16775850;
            5'd7:    v = 33'sd8388437;
            5'd8:    v = 33'sd4194282;
            5'd9:    v = 33'sd2097149;
            5'd10:   v = 33'sd1048575;
            5'd11:   v = 33'sd524287;
            5'd12:   v = 33'sd262143;
            5'd13:   v = 33'sd131071;
            5'd14:   v = 33'sd65535;
            5'd15:   v = 33'sd32767;
            5'd16:   v = 33'sd16383;
            5'd17:   v = 33'sd8191;
            5'd18:   v = 33'sd4095;
            5'd19:   v = 33'sd2047;
            5'd20:   v = 33'sd1023;
            5'd21:   v = 33'sd511;
            5'd22:   v = 33'sd255;
            5'd23:   v = 33'sd127;
            default: v = 33'sd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/usp_ctrl.sv =====
// ----------------------------------------------------------------------------
// usp_ctrl
// sequencer: walks the datapath through cordic, products, divisions, output
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module usp_ctrl #(
    parameter int CORDIC_STEPS = usp_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output usp_pkg::t_dp_cmd    o_cmd
);
    import usp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_CINIT, S_CORD, S_TFIN, S_MINIT, S_MUL,
        S_GINIT, S_GMUL, S_DINIT, S_DIV, S_STORE, S_OUT
    } t_state;

    localparam logic [CNT_W-1:0] CORD_LAST = CNT_W'(CORDIC_STEPS - 1);
    localparam logic [CNT_W-1:0] MUL_LAST  = CNT_W'(MUL_STEPS - 1);
    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(DIV_STEPS - 1);

    t_state           r_state;
    logic [CNT_W-1:0] r_cnt;
    logic [1:0]       r_phase;
    logic             r_comp;
    logic             r_out_valid;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // command decode
    always_comb begin
        o_cmd           = '0;
        o_cmd.mul_sel   = MS_CEX;
        o_cmd.idx       = r_cnt;
        o_cmd.comp      = r_comp;
        case (r_state)
            S_IDLE:  o_cmd.load      = i_in_valid;
            S_CINIT: o_cmd.cord_init = 1'b1;
            S_CORD:  o_cmd.cord_step = 1'b1;
            S_TFIN:  o_cmd.trig_fin  = 1'b1;
            S_MINIT: begin
                o_cmd.mul_init = 1'b1;
                o_cmd.mul_clr  = ~r_phase[0];
                o_cmd.cap_x    = (r_phase == 2'd2);
                case (r_phase)
                    2'd0:    o_cmd.mul_sel = MS_CEX;
                    2'd1:    o_cmd.mul_sel = MS_SEY;
                    2'd2:    o_cmd.mul_sel = MS_CEY;
                    default: o_cmd.mul_sel = MS_SEX_NEG;
                endcase
            end
            S_MUL:   o_cmd.mul_step = 1'b1;
            S_GINIT: begin
                o_cmd.mul_init = 1'b1;
                o_cmd.mul_clr  = 1'b1;
                o_cmd.mul_sel  = MS_GAIN;
                o_cmd.cap_y    = ~r_comp;
            end
            S_GMUL:  o_cmd.mul_step  = 1'b1;
            S_DINIT: o_cmd.div_init  = 1'b1;
            S_DIV:   o_cmd.div_step  = 1'b1;
            S_STORE: o_cmd.res_store = 1'b1;
            S_OUT:   o_cmd.out_load  = ~r_out_valid | i_out_ready;
            default: o_cmd.load      = 1'b0;
        endcase
    end

    // state, counters and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_phase     <= '0;
            r_comp      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_CINIT;
                    end
                end
                S_CINIT: begin
                    r_cnt   <= '0;
                    r_state <= S_CORD;
                end
                S_CORD: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CORD_LAST) begin
                        r_state <= S_TFIN;
                    end
                end
                S_TFIN: begin
                    r_phase <= '0;
                    r_state <= S_MINIT;
                end
                S_MINIT: begin
                    r_cnt   <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == MUL_LAST) begin
                        r_phase <= r_phase + 1'b1;
                        r_comp  <= 1'b0;
                        r_state <= (r_phase == 2'd3) ? S_GINIT : S_MINIT;
                    end
                end
                S_GINIT: begin
                    r_cnt   <= '0;
                    r_state <= S_GMUL;
                end
                S_GMUL: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == MUL_LAST) begin
                        r_state <= S_DINIT;
                    end
                end
                S_DINIT: begin
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == DIV_LAST) begin
                        r_state <= S_STORE;
                    end
                end
                S_STORE: begin
                    r_comp  <= 1'b1;
                    r_state <= r_comp ? S_OUT : S_GINIT;
                end
                S_OUT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/usp_datapath.sv =====
// ----------------------------------------------------------------------------
// usp_datapath
// config registers, origin, cordic, serial multiplier, restoring divider
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module usp_datapath #(
    parameter int FRAC_BITS = usp_pkg::FRAC_BITS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_wr_en,
    input  wire logic [2:0]          i_cfg_index,
    input  wire logic [31:0]         i_cfg_data,
    input  wire logic signed [31:0]  i_pose_x,
    input  wire logic signed [31:0]  i_pose_y,
    input  wire logic signed [15:0]  i_pose_heading,
    input  wire usp_pkg::t_dp_cmd    i_cmd,
    output logic signed [31:0]       o_linear_speed,
    output logic signed [31:0]       o_angular_speed
);
    import usp_pkg::*;

    localparam logic [63:0] ONE_W = 64'd1 << FRAC_BITS;
    localparam logic [63:0] OFS_W = 64'd1 << (FRAC_BITS - 2);

    // configuration
    logic signed [31:0] r_target_x, r_target_y;
    logic [23:0]        r_gain_lin, r_gain_ang, r_soft, r_offset;
    // origin
    logic signed [31:0] r_org_x, r_org_y;
    logic               r_org_valid;
    // per-item working registers
    logic signed [33:0] r_ex, r_ey;
    logic signed [15:0] r_h;
    logic signed [32:0] r_cx, r_cy, r_cz;
    logic               r_neg;
    logic signed [27:0] r_c, r_s;
    logic [27:0]        r_mplier;
    logic [63:0]        r_mcand, r_acc;
    logic signed [40:0] r_xm, r_ym;
    logic [63:0]        r_rem;
    logic [64:0]        r_dsh;
    logic [24:0]        r_q;
    logic               r_den_zero;
    logic [31:0]        r_res_lin, r_res_ang;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_x <= '0;
            r_target_y <= '0;
            r_gain_lin <= ONE_W[23:0];
            r_gain_ang <= ONE_W[23:0];
            r_soft     <= ONE_W[23:0];
            r_offset   <= OFS_W[23:0];
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_TARGET_X:     r_target_x <= i_cfg_data;
                REG_TARGET_Y:     r_target_y <= i_cfg_data;
                REG_GAIN_LINEAR:  r_gain_lin <= i_cfg_data[23:0];
                REG_GAIN_ANGULAR: r_gain_ang <= i_cfg_data[23:0];
                REG_SOFTENING:    r_soft     <= i_cfg_data[23:0];
                REG_OFFSET:       r_offset   <= i_cfg_data[23:0];
                default:          r_soft     <= r_soft;
            endcase
        end
    end

    // error to target, first sample becomes the origin
    logic signed [31:0] w_ox, w_oy;
    logic signed [33:0] w_ex, w_ey;
    assign w_ox = r_org_valid ? r_org_x : i_pose_x;
    assign w_oy = r_org_valid ? r_org_y : i_pose_y;
    assign w_ex = 34'(r_target_x) - (34'(i_pose_x) - 34'(w_ox));
    assign w_ey = 34'(r_target_y) - (34'(i_pose_y) - 34'(w_oy));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_org_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_org_x <= w_ox;
            r_org_y <= w_oy;
            r_ex    <= w_ex;
            r_ey    <= w_ey;
            r_h     <= i_pose_heading;
        end
    end

    // cordic rotation: quadrant fold, then one micro-rotation per cycle
    logic signed [15:0] w_hred;
    logic               w_hneg;
    logic signed [32:0] w_ysh, w_xsh, w_atan, w_cr, w_sr;
    always_comb begin
        w_hneg = 1'b1;
        if (r_h > HALF_PI_Q13) begin
            w_hred = r_h - PI_Q13;
        end else if (r_h < -HALF_PI_Q13) begin
            w_hred = r_h + PI_Q13;
        end else begin
            w_hred = r_h;
            w_hneg = 1'b0;
        end
    end
    assign w_ysh  = r_cy >>> i_cmd.idx;
    assign w_xsh  = r_cx >>> i_cmd.idx;
    assign w_atan = atan_q30(i_cmd.idx);
    assign w_cr   = (r_cx + 33'sd32) >>> 6;
    assign w_sr   = (r_cy + 33'sd32) >>> 6;

    always_ff @(posedge i_clk) begin
        if (i_cmd.cord_init) begin
            r_cx  <= CORDIC_GAIN_Q30;
            r_cy  <= '0;
            r_cz  <= {w_hred[15], w_hred, 16'b0} + {w_hred[15], w_hred, 16'b0};
            r_neg <= w_hneg;
        end else if (i_cmd.cord_step) begin
            if (!r_cz[32]) begin
                r_cx <= r_cx - w_ysh;
                r_cy <= r_cy + w_xsh;
                r_cz <= r_cz - w_atan;
            end else begin
                r_cx <= r_cx + w_ysh;
                r_cy <= r_cy - w_xsh;
                r_cz <= r_cz + w_atan;
            end
        end
        if (i_cmd.trig_fin) begin
            r_c <= r_neg ? -28'(w_cr) : 28'(w_cr);
            r_s <= r_neg ? -28'(w_sr) : 28'(w_sr);
        end
    end

    // operand selection for the serial multiplier
    logic signed [27:0] w_trig;
    logic signed [33:0] w_err;
    logic               w_flip;
    logic [27:0]        w_trig_mag;
    logic [63:0]        w_err_ext;
    logic signed [40:0] w_comp_e;
    logic [39:0]        w_mag;
    logic [23:0]        w_gain;
    always_comb begin
        w_flip = 1'b0;
        case (i_cmd.mul_sel)
            MS_CEX:     begin w_trig = r_c; w_err = r_ex; end
            MS_SEY:     begin w_trig = r_s; w_err = r_ey; end
            MS_CEY:     begin w_trig = r_c; w_err = r_ey; end
            MS_SEX_NEG: begin w_trig = r_s; w_err = r_ex; w_flip = 1'b1; end
            default:    begin w_trig = r_c; w_err = r_ex; end
        endcase
    end
    assign w_trig_mag = w_trig[27] ? 28'(-w_trig) : 28'(w_trig);
    assign w_err_ext  = (w_trig[27] ^ w_flip) ? 64'(-64'(w_err)) : 64'(w_err);
    assign w_comp_e   = i_cmd.comp ? r_ym : r_xm;
    assign w_mag      = w_comp_e[40] ? 40'(-w_comp_e) : w_comp_e[39:0];
    assign w_gain     = i_cmd.comp ? r_gain_ang : r_gain_lin;

    // shift-and-add multiply, one multiplier bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_init) begin
            if (i_cmd.mul_clr) begin
                r_acc <= '0;
            end
            if (i_cmd.mul_sel == MS_GAIN) begin
                r_mplier <= {4'b0, w_gain};
                r_mcand  <= {24'b0, w_mag};
            end else begin
                r_mplier <= w_trig_mag;
                r_mcand  <= w_err_ext;
            end
        end else if (i_cmd.mul_step) begin
            if (r_mplier[0]) begin
                r_acc <= r_acc + r_mcand;
            end
            r_mplier <= r_mplier >> 1;
            r_mcand  <= r_mcand << 1;
        end
    end

    // rounding of the rotated error back to the working scale
    logic [63:0]        w_rnd;
    logic signed [40:0] w_scaled;
    assign w_rnd    = r_acc + 64'd8388608;
    assign w_scaled = 41'(signed'(w_rnd[63:24]));

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_x) begin
            r_xm <= w_scaled - 41'(r_offset);
        end
        if (i_cmd.cap_y) begin
            r_ym <= w_scaled;
        end
    end

    // restoring division, one quotient bit per cycle
    logic [40:0] w_den;
    logic [24:0] w_qs;
    logic [31:0] w_res;
    assign w_den = 41'(r_soft) + 41'(w_mag);
    assign w_qs  = r_den_zero ? 25'd0 : r_q;
    assign w_res = w_comp_e[40] ? -32'(w_qs) : 32'(w_qs);

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_rem      <= r_acc;
            r_dsh      <= {w_den, 24'b0};
            r_q        <= '0;
            r_den_zero <= (w_den == '0);
        end else if (i_cmd.div_step) begin
            if ({1'b0, r_rem} >= r_dsh) begin
                r_rem <= r_rem - r_dsh[63:0];
                r_q   <= {r_q[23:0], 1'b1};
            end else begin
                r_q   <= {r_q[23:0], 1'b0};
            end
            r_dsh <= r_dsh >> 1;
        end
        if (i_cmd.res_store) begin
            if (i_cmd.comp) begin
                r_res_ang <= w_res;
            end else begin
                r_res_lin <= w_res;
            end
        end
        if (i_cmd.out_load) begin
            o_linear_speed  <= r_res_lin;
            o_angular_speed <= r_res_ang;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/unicycle_point_stabilizer.sv =====
// ----------------------------------------------------------------------------
// unicycle_point_stabilizer
// offset-point position controller: pose sample in, speed command out
// ----------------------------------------------------------------------------
//  channel   direction  payload (low bits first)
//  s_axis    in         pose_x[31:0], pose_y[63:32], pose_heading[79:64]
//  m_axis    out        linear_speed[31:0], angular_speed[63:32]
//  cfg       in         index 0..5, data up to 32 bits, write only
//
//  items run one at a time through the one shared shift-add multiplier
//  and divider; no new sample is taken until the current one is done
//  reset is synchronous and active low; origin re-latches on the next sample
//  a finished result sits in the output register while the next item runs;
//  the sequencer only waits at its end if that register is still occupied
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module unicycle_point_stabilizer #(
    parameter int FRAC_BITS    = usp_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = usp_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [79:0] i_s_axis_tdata,   // pose_x, pose_y, pose_heading
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [63:0]      o_m_axis_tdata,   // linear_speed, angular_speed
    input  wire logic        i_cfg_wr_en,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);
    import usp_pkg::*;

    t_dp_cmd            w_cmd;
    logic signed [31:0] w_lin, w_ang;

    // sequencer
    usp_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_cmd       (w_cmd)
    );

    // arithmetic
    usp_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_pose_x        (i_s_axis_tdata[31:0]),
        .i_pose_y        (i_s_axis_tdata[63:32]),
        .i_pose_heading  (i_s_axis_tdata[79:64]),
        .i_cmd           (w_cmd),
        .o_linear_speed  (w_lin),
        .o_angular_speed (w_ang)
    );

    assign o_m_axis_tdata = {w_ang, w_lin};

    `include "unicycle_point_stabilizer_assert.svh"

    // an accepted transaction makes the block busy at once
    `USP_ASSERT_NEXT(a_busy_after_accept, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready, "input taken while busy")
    // a new result is only raised as the sequencer returns to idle
    `USP_ASSERT_IMPL(a_result_ends_item, $rose(o_m_axis_tvalid), o_s_axis_tready, "result raised mid-item")
    // a load into the datapath only happens on an input transaction
    `USP_ASSERT_IMPL(a_load_on_accept, w_cmd.load, i_s_axis_tvalid && o_s_axis_tready, "stray load")

endmodule

`default_nettype wire
